FILE: rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, codes and sizes of the slip frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int MAX_FRAME = 256;
  localparam int FILL_W    = $clog2(MAX_FRAME + 1);
  localparam int ERRCNT_W  = 32;
  localparam int CODE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 9;
  localparam int POS_W     = 8;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_DATA = 3'b010,
    MODE_ESC  = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OVERFLOW = 2'd0,
    ERR_BAD_ESC  = 2'd1,
    ERR_START    = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START      = 3'd0,
    REG_END        = 3'd1,
    REG_ESC        = 3'd2,
    REG_ESC_END    = 3'd3,
    REG_ESC_ESC    = 3'd4,
    REG_ESC_START  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;
    logic [CODE_W-1:0] escape_code;
    logic [CODE_W-1:0] escaped_end_code;
    logic [CODE_W-1:0] escaped_escape_code;
    logic [CODE_W-1:0] escaped_start_code;
  } sfd_codes_t;

  typedef struct packed {
    mode_t               mode;
    logic [FILL_W-1:0]   fill_count;
    logic [ERRCNT_W-1:0] error_count;
  } sfd_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   data_byte;
    logic [POS_W-1:0]    byte_position;
    logic [LEN_W-1:0]    frame_length;
    logic [1:0]          error_kind;
    logic [ERRCNT_W-1:0] error_total;
  } sfd_result_t;

endpackage

FILE: rtl/core/slip_frame_decoder.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder
// slip framing decoder with start delimiter, one byte per word
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_write            cfg_index, cfg_data
//   in        in         in_valid / in_stall  rx_byte
//   out       out        out_valid/out_stall  kind, data_byte, byte_position,
//                                             frame_length, error_kind,
//                                             error_total
//
// one word per cycle sustained while the output is not stalled
// stage one is the input register, stage two the result register
// decode and state update sit between the two
// out_stall holds both stages; in_stall rises only while stage one is full
// rst is synchronous, clears mode, fill count and error count, reloads codes
// ----------------------------------------------------------------------------
module slip_frame_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfd_pkg::CODE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sfd_pkg::CODE_W-1:0]          rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic [sfd_pkg::CODE_W-1:0]          data_byte,
  output logic [sfd_pkg::POS_W-1:0]           byte_position,
  output logic [sfd_pkg::LEN_W-1:0]           frame_length,
  output logic [1:0]                          error_kind,
  output logic [sfd_pkg::ERRCNT_W-1:0]        error_total
);
  import sfd_pkg::*;

  sfd_codes_t        codes;
  sfd_state_t        state;
  sfd_state_t        state_next;
  sfd_result_t       step_result;
  sfd_result_t       result;
  logic              s1_valid;
  logic [CODE_W-1:0] s1_byte;
  logic              out_ready;
  logic              load;
  logic              accept_in;

  sfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  sfd_step u_step (
    .codes      (codes),
    .state      (state),
    .rx_byte    (s1_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  assign out_ready = !out_valid || !out_stall;
  assign load      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_IDLE;
      state.fill_count  <= '0;
      state.error_count <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= step_result;
    end
  end

  assign kind          = result.kind;
  assign data_byte     = result.data_byte;
  assign byte_position = result.byte_position;
  assign frame_length  = result.frame_length;
  assign error_kind    = result.error_kind;
  assign error_total   = result.error_total;

  a_err_count: assert property (@(posedge clk) disable iff (rst)
    (load && step_result.kind == KIND_ERR)
      |=> state.error_count == $past(state.error_count) + 1'b1)
    else $error("error count did not advance on an error word");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state.fill_count <= FILL_W'(MAX_FRAME))
    else $error("fill count beyond frame capacity");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_IDLE |-> state.fill_count == '0)
    else $error("idle with nonzero fill count");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: rtl/core/sfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfd_cfg_regs
// framing code registers, written through the plain write port
// ----------------------------------------------------------------------------
module sfd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CODE_W-1:0]     cfg_data,
  output sfd_pkg::sfd_codes_t            codes
);
  import sfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code          <= 8'd193;
      codes.end_code            <= 8'd192;
      codes.escape_code         <= 8'd219;
      codes.escaped_end_code    <= 8'd220;
      codes.escaped_escape_code <= 8'd221;
      codes.escaped_start_code  <= 8'd222;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START:     codes.start_code          <= cfg_data;
        REG_END:       codes.end_code            <= cfg_data;
        REG_ESC:       codes.escape_code         <= cfg_data;
        REG_ESC_END:   codes.escaped_end_code    <= cfg_data;
        REG_ESC_ESC:   codes.escaped_escape_code <= cfg_data;
        REG_ESC_START: codes.escaped_start_code  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/sfd_step.sv
// ----------------------------------------------------------------------------
// sfd_step
// decode of one received byte: next state and result word
// ----------------------------------------------------------------------------
module sfd_step (
  input  sfd_pkg::sfd_codes_t          codes,
  input  sfd_pkg::sfd_state_t          state,
  input  logic [sfd_pkg::CODE_W-1:0]   rx_byte,
  output sfd_pkg::sfd_state_t          state_next,
  output sfd_pkg::sfd_result_t         result
);
  import sfd_pkg::*;

  logic [FILL_W-1:0] fill_inc;

  assign fill_inc = FILL_W'(state.fill_count + 1'b1);

  always_comb begin
    state_next = state;
    result     = '0;
    case (state.mode)
      MODE_DATA, MODE_ESC: begin
        if (state.fill_count >= FILL_W'(MAX_FRAME)) begin
          state_next.mode        = MODE_IDLE;
          state_next.fill_count  = '0;
          state_next.error_count = state.error_count + 1'b1;
          result.kind            = KIND_ERR;
          result.error_kind      = ERR_OVERFLOW;
        end else if (state.mode == MODE_ESC) begin
          if (rx_byte == codes.escaped_escape_code) begin
            result.kind      = KIND_DATA;
            result.data_byte = codes.escape_code;
          end else if (rx_byte == codes.escaped_end_code) begin
            result.kind      = KIND_DATA;
            result.data_byte = codes.end_code;
          end else if (rx_byte == codes.escaped_start_code) begin
            result.kind      = KIND_DATA;
            result.data_byte = codes.start_code;
          end else begin
            state_next.mode        = MODE_IDLE;
            state_next.fill_count  = '0;
            state_next.error_count = state.error_count + 1'b1;
            result.kind            = KIND_ERR;
            result.error_kind      = ERR_BAD_ESC;
          end
        end else begin
          if (rx_byte == codes.end_code) begin
            state_next.mode       = MODE_IDLE;
            state_next.fill_count = '0;
            result.kind           = KIND_DONE;
            result.frame_length   = LEN_W'(state.fill_count);
          end else if (rx_byte == codes.escape_code) begin
            state_next.mode = MODE_ESC;
          end else if (rx_byte == codes.start_code) begin
            state_next.mode        = MODE_IDLE;
            state_next.fill_count  = '0;
            state_next.error_count = state.error_count + 1'b1;
            result.kind            = KIND_ERR;
            result.error_kind      = ERR_START;
          end else begin
            result.kind      = KIND_DATA;
            result.data_byte = rx_byte;
          end
        end
        if (result.kind == KIND_DATA) begin
          result.byte_position  = POS_W'(state.fill_count);
          state_next.fill_count = fill_inc;
          state_next.mode       = MODE_DATA;
        end
      end
      default: begin
        state_next.fill_count = '0;
        state_next.mode       = (rx_byte == codes.start_code) ? MODE_DATA : MODE_IDLE;
      end
    endcase
    result.error_total = state_next.error_count;
  end

endmodule
